/* rtl/core/multi_track_audio_mixer_core_macros.svh */
// Assertion macros shared by the multi-track audio mixer core.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef MULTI_TRACK_AUDIO_MIXER_CORE_MACROS_SVH
`define MULTI_TRACK_AUDIO_MIXER_CORE_MACROS_SVH

// The property holds at every clock edge out of reset.
`define MTAM_ASSERT_HOLDS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define MTAM_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the following cycle.
`define MTAM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mtam_pkg.sv */
// Types and constants shared by the multi-track audio mixer core.
// No dependencies; imported by mtam_front, mtam_back and the top level.
package mtam_pkg;

    // Field widths of the streaming words.
    localparam int SAMPLE_W = 16;
    localparam int TSEL_W   = 2;
    localparam int OP_W     = 2;
    localparam int CH_W     = 3;
    localparam int NCH_W    = 4;
    localparam int IN_USER_W  = OP_W + TSEL_W;
    localparam int OUT_USER_W = CH_W;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;
    localparam int GAIN_W     = 10;
    localparam int MUTE_W     = 4;
    localparam int GAIN_REGS  = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_GAIN0  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN1  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN2  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN3  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MUTE   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CHCNT  = 3'd5;

    localparam logic [GAIN_W-1:0] GAIN_RESET  = 10'd256;
    localparam logic [GAIN_W-1:0] GAIN_MAX    = 10'd512;
    localparam logic [NCH_W-1:0]  CHCNT_RESET = 4'd2;
    localparam int GAIN_FRAC = 8;

    // Arithmetic widths: sample times gain, the scaled value and a four-track sum.
    localparam int PROD_W = 27;
    localparam int SCL_W  = 18;
    localparam int ACC_W  = 21;
    localparam logic signed [ACC_W-1:0] SAT_HI = 21'sd32767;
    localparam logic signed [ACC_W-1:0] SAT_LO = -21'sd32768;
    localparam logic [SAMPLE_W-1:0] SAMPLE_HI = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_LO = 16'h8000;

    // Channel sums kept for one frame.
    localparam int CH_LIMIT = 8;

    // Command queue between the front and the back.
    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_MIX   = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic [TSEL_W-1:0]          trk;
        logic signed [SAMPLE_W-1:0] sample;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_MIX   = 2'd1,
        BK_DRAIN = 2'd2,
        BK_EMIT  = 2'd3
    } bk_state_t;

endpackage

/* rtl/core/mtam_front.sv */
// Front end of the mixer: accepts input words, drops those with no effect
// and queues the rest as commands. Depends on mtam_pkg and the macro header.
`include "multi_track_audio_mixer_core_macros.svh"

module mtam_front #(
    parameter int NUM_TRACKS = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // sample_in
    input  logic [mtam_pkg::SAMPLE_W-1:0]      s_tdata,
    // opcode [1:0], track_sel [3:2]
    input  logic [mtam_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                               cmd_valid,
    output mtam_pkg::cmd_t                     cmd,
    input  logic                               cmd_pop
);
    import mtam_pkg::*;

    localparam logic [TSEL_W:0] NT = (TSEL_W+1)'(NUM_TRACKS);

    cmd_t                cq_mem_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] cq_wr_reg;
    logic [CQ_PTR_W-1:0] cq_rd_reg;
    logic [CQ_PTR_W:0]   cq_cnt_reg;

    cmd_t  in_cmd;
    logic  in_acc;
    logic  in_keep;
    logic  cq_push;

    // Decode the incoming word and decide whether it does anything.
    always_comb begin
        in_cmd.op     = op_t'(s_tuser[OP_W-1:0]);
        in_cmd.trk    = s_tuser[IN_USER_W-1:OP_W];
        in_cmd.sample = s_tdata;
        case (in_cmd.op)
            OP_PUSH:  in_keep = {1'b0, in_cmd.trk} < NT;
            OP_MIX:   in_keep = 1'b1;
            OP_FLUSH: in_keep = 1'b1;
            default:  in_keep = 1'b0;
        endcase
    end

    assign s_tready  = cq_cnt_reg != (CQ_PTR_W+1)'(CQ_DEPTH);
    assign in_acc    = s_tvalid && s_tready;
    assign cq_push   = in_acc && in_keep;
    assign cmd_valid = cq_cnt_reg != '0;
    assign cmd       = cq_mem_reg[cq_rd_reg];

    // Queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cq_wr_reg  <= '0;
            cq_rd_reg  <= '0;
            cq_cnt_reg <= '0;
        end else begin
            if (cq_push) begin
                cq_wr_reg <= cq_wr_reg + 1'b1;
            end
            if (cmd_pop) begin
                cq_rd_reg <= cq_rd_reg + 1'b1;
            end
            if (cq_push && !cmd_pop) begin
                cq_cnt_reg <= cq_cnt_reg + 1'b1;
            end else if (!cq_push && cmd_pop) begin
                cq_cnt_reg <= cq_cnt_reg - 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (cq_push) begin
            cq_mem_reg[cq_wr_reg] <= in_cmd;
        end
    end

    `MTAM_ASSERT_HOLDS(a_cq_bound, cq_cnt_reg <= (CQ_PTR_W+1)'(CQ_DEPTH), "queue overfilled")
    `MTAM_ASSERT_IMPLIES(a_cq_pop_valid, cmd_pop, cq_cnt_reg != '0, "pop from empty queue")

endmodule

/* rtl/core/mtam_back.sv */
// Back end of the mixer: track FIFOs in one sample memory, the gain and sum
// pipeline, the configuration registers and the output word register.
// Depends on mtam_pkg and the macro header.
`include "multi_track_audio_mixer_core_macros.svh"

module mtam_back #(
    parameter int NUM_TRACKS   = 4,
    parameter int FIFO_DEPTH   = 1024,
    parameter int MAX_CHANNELS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mtam_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mtam_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                cmd_valid,
    input  mtam_pkg::cmd_t                      cmd,
    output logic                                cmd_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // mixed_sample
    output logic [mtam_pkg::SAMPLE_W-1:0]       m_tdata,
    // channel_index
    output logic [mtam_pkg::OUT_USER_W-1:0]     m_tuser,
    output logic                                m_tlast
);
    import mtam_pkg::*;

    localparam int TRK_W     = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
    localparam int PTR_W     = $clog2(FIFO_DEPTH);
    localparam int FILL_W    = PTR_W + 1;
    localparam int ADDR_W    = TRK_W + PTR_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam logic [FILL_W-1:0] DEPTH_F  = FILL_W'(FIFO_DEPTH);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [TRK_W-1:0]  LAST_TRK = TRK_W'(NUM_TRACKS - 1);
    localparam logic [NCH_W-1:0]  MAXCH    = NCH_W'(MAX_CHANNELS);
    localparam logic signed [PROD_W-1:0] RND = PROD_W'((1 << GAIN_FRAC) - 1);

    // Configuration registers.
    logic [GAIN_W-1:0] gain_reg [GAIN_REGS];
    logic [MUTE_W-1:0] mute_reg;
    logic [NCH_W-1:0]  chcnt_reg;

    // Track FIFO state.
    logic [PTR_W-1:0]  rp_reg   [NUM_TRACKS];
    logic [PTR_W-1:0]  wp_reg   [NUM_TRACKS];
    logic [FILL_W-1:0] fill_reg [NUM_TRACKS];
    logic [SAMPLE_W-1:0] mem [MEM_DEPTH];

    // Sequencer and pipeline control.
    bk_state_t           state_reg, state_next;
    logic [NCH_W-1:0]    nch_reg;
    logic [NUM_TRACKS-1:0] contrib_reg;
    logic [CH_W-1:0]     iss_ch_reg;
    logic [TRK_W-1:0]    iss_trk_reg;
    logic [CH_W-1:0]     em_idx_reg;
    logic                p1_vld_reg, p2_vld_reg, out_vld_reg;

    // Pipeline payload.
    logic [SAMPLE_W-1:0]       rd_data_reg;
    logic [CH_W-1:0]           p1_ch_reg, p2_ch_reg;
    logic [TRK_W-1:0]          p1_trk_reg;
    logic                      p1_first_reg, p2_first_reg;
    logic                      p1_last_reg, p2_last_reg;
    logic                      p1_use_reg, p2_use_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [SAMPLE_W-1:0]       sat_reg [CH_LIMIT];
    logic [SAMPLE_W-1:0]       out_sample_reg;
    logic [CH_W-1:0]           out_ch_reg;
    logic                      out_last_reg;

    logic                do_push, do_flush, mix_start, issue_en, ptr_upd, emit_load;
    logic                push_ok, mem_we;
    logic [TRK_W-1:0]    cmd_trk;
    logic [ADDR_W-1:0]   wr_addr, rd_addr;
    logic [NCH_W-1:0]    nch_clamp;
    logic [NUM_TRACKS-1:0] contrib_next;
    logic                iss_trk_last, iss_ch_last, em_last;
    logic [GAIN_W-1:0]   g_raw, g_clamp;
    logic signed [PROD_W-1:0] s_ext, g_ext, prod_next, shifted;
    logic signed [SCL_W-1:0]  scl;
    logic signed [ACC_W-1:0]  acc_sum;
    logic [SAMPLE_W-1:0] sat_val;

    // Pointer advance by up to one frame, wrapping at the FIFO depth.
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                  input logic [NCH_W-1:0] k);
        logic [FILL_W-1:0] s;
        s = {1'b0, p} + FILL_W'(k);
        if (s >= DEPTH_F) begin
            s = s - DEPTH_F;
        end
        return s[PTR_W-1:0];
    endfunction

    // Command decode helpers.
    always_comb begin
        cmd_trk = cmd.trk[TRK_W-1:0];
        push_ok = !mute_reg[cmd_trk] && (fill_reg[cmd_trk] < DEPTH_F);
        wr_addr = {cmd_trk, wp_reg[cmd_trk]};
        if (chcnt_reg == '0) begin
            nch_clamp = NCH_W'(1);
        end else if (chcnt_reg > MAXCH) begin
            nch_clamp = MAXCH;
        end else begin
            nch_clamp = chcnt_reg;
        end
        for (int t = 0; t < NUM_TRACKS; t++) begin
            contrib_next[t] = !mute_reg[t] && (fill_reg[t] >= FILL_W'(nch_clamp));
        end
        iss_trk_last = iss_trk_reg == LAST_TRK;
        iss_ch_last  = NCH_W'(iss_ch_reg) + 1'b1 == nch_reg;
        em_last      = NCH_W'(em_idx_reg) + 1'b1 == nch_reg;
        rd_addr      = {iss_trk_reg, ptr_add(rp_reg[iss_trk_reg], NCH_W'(iss_ch_reg))};
    end

    // Sequencer state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencer next state and strobes.
    always_comb begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        do_push    = 1'b0;
        do_flush   = 1'b0;
        mix_start  = 1'b0;
        issue_en   = 1'b0;
        ptr_upd    = 1'b0;
        emit_load  = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_PUSH:  do_push  = 1'b1;
                        OP_FLUSH: do_flush = 1'b1;
                        OP_MIX: begin
                            mix_start  = 1'b1;
                            state_next = BK_MIX;
                        end
                        default: ;
                    endcase
                end
            end
            BK_MIX: begin
                issue_en = 1'b1;
                if (iss_trk_last && iss_ch_last) begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                if (!p1_vld_reg && !p2_vld_reg) begin
                    ptr_upd    = 1'b1;
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (!out_vld_reg || m_tready) begin
                    emit_load = 1'b1;
                    if (em_last) begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    assign mem_we = do_push && push_ok;

    // Gain, truncation toward zero, channel sum and saturation.
    always_comb begin
        g_raw     = gain_reg[p1_trk_reg];
        g_clamp   = (g_raw > GAIN_MAX) ? GAIN_MAX : g_raw;
        s_ext     = {{(PROD_W-SAMPLE_W){rd_data_reg[SAMPLE_W-1]}}, rd_data_reg};
        g_ext     = {{(PROD_W-GAIN_W){1'b0}}, g_clamp};
        prod_next = s_ext * g_ext;
        if (prod_reg[PROD_W-1]) begin
            shifted = (prod_reg + RND) >>> GAIN_FRAC;
        end else begin
            shifted = prod_reg >>> GAIN_FRAC;
        end
        scl     = shifted[SCL_W-1:0];
        acc_sum = (p2_first_reg ? '0 : acc_reg)
                + (p2_use_reg ? {{(ACC_W-SCL_W){scl[SCL_W-1]}}, scl} : '0);
        if (acc_sum > SAT_HI) begin
            sat_val = SAMPLE_HI;
        end else if (acc_sum < SAT_LO) begin
            sat_val = SAMPLE_LO;
        end else begin
            sat_val = acc_sum[SAMPLE_W-1:0];
        end
    end

    // Control registers: configuration, FIFO pointers, loop counters, valids.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < GAIN_REGS; i++) begin
                gain_reg[i] <= GAIN_RESET;
            end
            mute_reg  <= '0;
            chcnt_reg <= CHCNT_RESET;
            for (int t = 0; t < NUM_TRACKS; t++) begin
                rp_reg[t]   <= '0;
                wp_reg[t]   <= '0;
                fill_reg[t] <= '0;
            end
            nch_reg     <= '0;
            contrib_reg <= '0;
            iss_ch_reg  <= '0;
            iss_trk_reg <= '0;
            em_idx_reg  <= '0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_GAIN0: gain_reg[0] <= cfg_wdata[GAIN_W-1:0];
                    REG_GAIN1: gain_reg[1] <= cfg_wdata[GAIN_W-1:0];
                    REG_GAIN2: gain_reg[2] <= cfg_wdata[GAIN_W-1:0];
                    REG_GAIN3: gain_reg[3] <= cfg_wdata[GAIN_W-1:0];
                    REG_MUTE:  mute_reg    <= cfg_wdata[MUTE_W-1:0];
                    REG_CHCNT: chcnt_reg   <= cfg_wdata[NCH_W-1:0];
                    default: ;
                endcase
            end

            if (do_flush) begin
                for (int t = 0; t < NUM_TRACKS; t++) begin
                    rp_reg[t]   <= '0;
                    wp_reg[t]   <= '0;
                    fill_reg[t] <= '0;
                end
            end

            if (mem_we) begin
                wp_reg[cmd_trk]   <= (wp_reg[cmd_trk] == PTR_LAST) ? '0
                                                                   : wp_reg[cmd_trk] + 1'b1;
                fill_reg[cmd_trk] <= fill_reg[cmd_trk] + 1'b1;
            end

            if (mix_start) begin
                nch_reg     <= nch_clamp;
                contrib_reg <= contrib_next;
                iss_ch_reg  <= '0;
                iss_trk_reg <= '0;
            end

            if (issue_en) begin
                if (iss_trk_last) begin
                    iss_trk_reg <= '0;
                    iss_ch_reg  <= iss_ch_reg + 1'b1;
                end else begin
                    iss_trk_reg <= iss_trk_reg + 1'b1;
                end
            end

            // One frame popped from every contributing track.
            if (ptr_upd) begin
                for (int t = 0; t < NUM_TRACKS; t++) begin
                    if (contrib_reg[t]) begin
                        rp_reg[t]   <= ptr_add(rp_reg[t], nch_reg);
                        fill_reg[t] <= fill_reg[t] - FILL_W'(nch_reg);
                    end
                end
                em_idx_reg <= '0;
            end

            p1_vld_reg <= issue_en;
            p2_vld_reg <= p1_vld_reg;

            if (emit_load) begin
                em_idx_reg  <= em_idx_reg + 1'b1;
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Sample memory: one write port for pushes, one registered read port for mixing.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= cmd.sample;
        end
        if (issue_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Pipeline payload and output word.
    always_ff @(posedge aclk) begin
        p1_ch_reg    <= iss_ch_reg;
        p1_trk_reg   <= iss_trk_reg;
        p1_first_reg <= iss_trk_reg == '0;
        p1_last_reg  <= iss_trk_last;
        p1_use_reg   <= contrib_reg[iss_trk_reg];

        p2_ch_reg    <= p1_ch_reg;
        p2_first_reg <= p1_first_reg;
        p2_last_reg  <= p1_last_reg;
        p2_use_reg   <= p1_use_reg;
        prod_reg     <= prod_next;

        if (p2_vld_reg) begin
            acc_reg <= acc_sum;
            if (p2_last_reg) begin
                sat_reg[p2_ch_reg] <= sat_val;
            end
        end

        if (emit_load) begin
            out_sample_reg <= sat_reg[em_idx_reg];
            out_ch_reg     <= em_idx_reg;
            out_last_reg   <= em_last;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tuser  = out_ch_reg;
    assign m_tlast  = out_last_reg;

    for (genvar t = 0; t < NUM_TRACKS; t++) begin : g_fill_chk
        `MTAM_ASSERT_HOLDS(a_fill_bound, fill_reg[t] <= DEPTH_F, "track fill above depth")
    end
    `MTAM_ASSERT_IMPLIES(a_emit_drained, state_reg == BK_EMIT, !p1_vld_reg && !p2_vld_reg, "emit before pipeline drained")
    `MTAM_ASSERT_IMPLIES(a_sum_channel, p2_vld_reg && p2_last_reg, NCH_W'(p2_ch_reg) < nch_reg, "channel sum beyond frame")
    `MTAM_ASSERT_NEXT(a_frame_done, emit_load && em_last, state_reg == BK_IDLE, "sequencer not idle after frame")

endmodule

/* rtl/core/multi_track_audio_mixer_core.sv */
// Multi-track PCM audio mixer with per-track gain and 16-bit saturation.
// A push or flush is handled by the back end, and a word with no effect is
// dropped in the front end without reaching it. Words queue in a four-entry
// command queue, so pushes stream at one per cycle while no mix is running. A mix takes
// the command, walks the sample memory (one read port, one sample per track and
// channel), drains the gain and sum pipeline and then sends one word per channel,
// held while m_tready is low. The user must write configuration only while the
// mixer is idle; the block itself does not enforce it. The sample memory is not
// cleared after reset.
// Depends on mtam_pkg, mtam_front and mtam_back.

module multi_track_audio_mixer_core #(
    parameter int NUM_TRACKS   = 4,
    parameter int FIFO_DEPTH   = 1024,
    parameter int MAX_CHANNELS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mtam_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mtam_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sample_in
    input  logic [mtam_pkg::SAMPLE_W-1:0]       s_tdata,
    // opcode [1:0], track_sel [3:2]
    input  logic [mtam_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // mixed_sample
    output logic [mtam_pkg::SAMPLE_W-1:0]       m_tdata,
    // channel_index
    output logic [mtam_pkg::OUT_USER_W-1:0]     m_tuser,
    output logic                                m_tlast
);
    import mtam_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    // Input word decode and command queue.
    mtam_front #(
        .NUM_TRACKS (NUM_TRACKS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Track FIFOs, mixing pipeline and output word register.
    mtam_back #(
        .NUM_TRACKS   (NUM_TRACKS),
        .FIFO_DEPTH   (FIFO_DEPTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* sim/multi_track_audio_mixer_core_tb.sv */
// Self-checking testbench for the multi-track audio mixer core.
// It predicts every mixed word from its own model of the track FIFOs and gains.
// Depends on mtam_pkg and multi_track_audio_mixer_core.
`timescale 1ns / 100ps

module multi_track_audio_mixer_core_tb;
    import mtam_pkg::*;

    localparam int TRACKS       = 4;
    localparam int FIFO_WORDS   = 1024;
    localparam int CHANNELS_MAX = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 64;
    localparam int IDLE_PCT     = 36;
    localparam int BURST_WORDS  = 44;
    localparam int PHASE_WORDS  = 60;
    localparam int DUE_DEPTH    = 256;

    // One mixed word as it leaves the block.
    typedef struct packed {
        logic [SAMPLE_W-1:0] mixed;
        logic [CH_W-1:0]     chan;
        logic                last;
    } mix_word_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // sample_in
    logic [SAMPLE_W-1:0]   s_tdata   = '0;
    // opcode [1:0], track_sel [3:2]
    logic [IN_USER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // mixed_sample
    logic [SAMPLE_W-1:0]   m_tdata;
    // channel_index
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  m_tlast;

    // Mixer settings as last written.
    logic [GAIN_W-1:0] track_gain [TRACKS];
    logic [MUTE_W-1:0] mute_bits;
    logic [NCH_W-1:0]  frame_channels;

    // Track FIFOs of the prediction.
    logic signed [SAMPLE_W-1:0] track_mem [TRACKS][FIFO_WORDS];
    int rd_ptr [TRACKS];
    int wr_ptr [TRACKS];
    int fill   [TRACKS];

    // Predicted words in order, as a ring with running write and read counts.
    mix_word_t due_mem [DUE_DEPTH];
    int  due_wr        = 0;
    int  due_rd        = 0;

    int  errors        = 0;
    int  words_sent    = 0;
    int  words_checked = 0;
    int  frames_seen   = 0;
    int  settings_used = 0;
    bit  steady        = 1'b0;
    bit  hold_req      = 1'b0;
    int  hold_count    = 0;

    multi_track_audio_mixer_core #(
        .NUM_TRACKS  (TRACKS),
        .FIFO_DEPTH  (FIFO_WORDS),
        .MAX_CHANNELS(CHANNELS_MAX)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // Channels per frame after the zero and upper limits are applied.
    function automatic int frame_width();
        if (frame_channels == 0) return 1;
        if (frame_channels > CHANNELS_MAX) return CHANNELS_MAX;
        return int'(frame_channels);
    endfunction

    // Advance the prediction by one accepted word; a mix queues its channel words.
    task automatic apply_word(input op_t op, input logic [TSEL_W-1:0] trk,
                              input logic signed [SAMPLE_W-1:0] smp);
        int sums [CHANNELS_MAX];
        int n;
        int prod;
        int part;
        logic [GAIN_W-1:0] g;
        mix_word_t w;
        case (op)
            OP_PUSH: begin
                if (!mute_bits[trk] && fill[trk] < FIFO_WORDS) begin
                    track_mem[trk][wr_ptr[trk]] = smp;
                    wr_ptr[trk] = (wr_ptr[trk] + 1) % FIFO_WORDS;
                    fill[trk]++;
                end
            end
            OP_FLUSH: begin
                for (int t = 0; t < TRACKS; t++) begin
                    rd_ptr[t] = 0;
                    wr_ptr[t] = 0;
                    fill[t]   = 0;
                end
            end
            OP_MIX: begin
                n = frame_width();
                for (int ch = 0; ch < CHANNELS_MAX; ch++) sums[ch] = 0;
                for (int t = 0; t < TRACKS; t++) begin
                    if (!mute_bits[t] && fill[t] >= n) begin
                        g = (track_gain[t] > GAIN_MAX) ? GAIN_MAX : track_gain[t];
                        for (int ch = 0; ch < n; ch++) begin
                            prod = int'(track_mem[t][rd_ptr[t]]) * int'(g);
                            // Scaling truncates towards zero, not towards minus infinity.
                            part = (prod < 0) ? -((-prod) >>> GAIN_FRAC) : (prod >>> GAIN_FRAC);
                            sums[ch] += part;
                            rd_ptr[t] = (rd_ptr[t] + 1) % FIFO_WORDS;
                            fill[t]--;
                        end
                    end
                end
                for (int ch = 0; ch < n; ch++) begin
                    if (sums[ch] > 32767) sums[ch] = 32767;
                    if (sums[ch] < -32768) sums[ch] = -32768;
                    w.mixed = sums[ch][SAMPLE_W-1:0];
                    w.chan  = ch[CH_W-1:0];
                    w.last  = (ch == n - 1);
                    due_mem[due_wr % DUE_DEPTH] = w;
                    due_wr++;
                end
            end
            OP_NONE: ;
        endcase
    endtask

    // Offer one word and wait for the handshake.
    task automatic send_word(input op_t op, input logic [TSEL_W-1:0] trk,
                             input logic [SAMPLE_W-1:0] smp);
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= {trk, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_word(op, trk, smp);
        if (op != OP_NONE) words_sent++;
    endtask

    task automatic release_input();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (due_wr != due_rd) @(posedge aclk);
    endtask

    // Stop sending, let every mixed word arrive and the command queue empty.
    task automatic wait_idle();
        release_input();
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Write all six registers in a row; only called while the mixer is idle.
    task automatic set_mixer(input logic [GAIN_W-1:0] g0, input logic [GAIN_W-1:0] g1,
                             input logic [GAIN_W-1:0] g2, input logic [GAIN_W-1:0] g3,
                             input logic [MUTE_W-1:0] mute, input logic [NCH_W-1:0] nch);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_GAIN0;
        cfg_wdata <= g0;
        @(posedge aclk);
        cfg_addr  <= REG_GAIN1;
        cfg_wdata <= g1;
        @(posedge aclk);
        cfg_addr  <= REG_GAIN2;
        cfg_wdata <= g2;
        @(posedge aclk);
        cfg_addr  <= REG_GAIN3;
        cfg_wdata <= g3;
        @(posedge aclk);
        cfg_addr  <= REG_MUTE;
        cfg_wdata <= {{(CFG_DATA_W-MUTE_W){1'b0}}, mute};
        @(posedge aclk);
        cfg_addr  <= REG_CHCNT;
        cfg_wdata <= {{(CFG_DATA_W-NCH_W){1'b0}}, nch};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        track_gain[0]  = g0;
        track_gain[1]  = g1;
        track_gain[2]  = g2;
        track_gain[3]  = g3;
        mute_bits      = mute;
        frame_channels = nch;
        settings_used++;
    endtask

    // Samples lean towards full scale so that the sums saturate often.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_HI;
            1:       return SAMPLE_LO;
            default: return SAMPLE_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return GAIN_MAX;
            2:       return GAIN_RESET;
            default: return GAIN_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // Fill most tracks with one frame's worth of samples, then mix.
    task automatic random_frame();
        int n;
        for (int t = 0; t < TRACKS; t++) begin
            if ($urandom_range(0, 9) < 7) begin
                n = frame_width() - (($urandom_range(0, 7) == 0) ? 1 : 0);
                for (int i = 0; i < n; i++) send_word(OP_PUSH, t[TSEL_W-1:0], pick_sample());
            end
        end
        send_word(OP_MIX, TSEL_W'($urandom_range(0, 3)),
                  SAMPLE_W'($urandom_range(0, 16'hFFFF)));
    endtask

    // Full-scale sums in both directions at reset settings, a short track
    // and an ignored opcode.
    task automatic test_saturation();
        send_word(OP_PUSH, 2'd0, SAMPLE_HI);
        send_word(OP_PUSH, 2'd0, SAMPLE_LO);
        send_word(OP_PUSH, 2'd1, SAMPLE_HI);
        send_word(OP_PUSH, 2'd1, SAMPLE_LO);
        send_word(OP_PUSH, 2'd2, 16'h0001);
        send_word(OP_PUSH, 2'd2, 16'hFFFF);
        send_word(OP_PUSH, 2'd3, 16'h1234);
        send_word(OP_MIX, 2'd0, 16'h0000);
        send_word(OP_NONE, 2'd3, 16'hFFFF);
        // Nothing left that fills a frame: every channel comes out as zero.
        send_word(OP_MIX, 2'd3, 16'hA5A5);
    endtask

    // Zero gain, the 2.0 ceiling, a gain above it and a tiny gain.
    task automatic test_gain_limits();
        wait_idle();
        set_mixer(10'd0, GAIN_MAX, 10'd1023, 10'd1, 4'b0000, 4'd1);
        send_word(OP_PUSH, 2'd0, SAMPLE_HI);
        send_word(OP_PUSH, 2'd1, SAMPLE_LO);
        send_word(OP_PUSH, 2'd2, SAMPLE_HI);
        send_word(OP_PUSH, 2'd3, 16'hFF01);
        send_word(OP_MIX, 2'd0, 16'h0000);
        send_word(OP_PUSH, 2'd2, 16'h8001);
        send_word(OP_PUSH, 2'd3, 16'hFF01);
        send_word(OP_MIX, 2'd1, 16'h0000);
    endtask

    // Channel count of zero, a push to a muted track, a track muted while it
    // holds samples, and a flush.
    task automatic test_mute_and_flush();
        wait_idle();
        set_mixer(GAIN_RESET, GAIN_RESET, GAIN_RESET, GAIN_RESET, 4'b0000, 4'd0);
        send_word(OP_PUSH, 2'd2, 16'h0100);
        send_word(OP_PUSH, 2'd2, 16'hFF00);
        wait_idle();
        set_mixer(GAIN_RESET, GAIN_RESET, GAIN_RESET, GAIN_RESET, 4'b0100, 4'd0);
        send_word(OP_PUSH, 2'd2, 16'h7777);
        send_word(OP_PUSH, 2'd0, 16'h0010);
        send_word(OP_MIX, 2'd0, 16'h0000);
        wait_idle();
        set_mixer(GAIN_RESET, GAIN_RESET, GAIN_RESET, GAIN_RESET, 4'b0000, 4'd0);
        send_word(OP_MIX, 2'd0, 16'h0000);
        send_word(OP_PUSH, 2'd1, 16'h55AA);
        send_word(OP_FLUSH, 2'd0, 16'h0000);
        send_word(OP_MIX, 2'd0, 16'h0000);
    endtask

    // A long burst into one track, then drain it frame by frame past its end.
    task automatic test_long_burst();
        wait_idle();
        set_mixer(GAIN_RESET, GAIN_RESET, GAIN_RESET, GAIN_RESET, 4'b0000, 4'd8);
        steady = 1'b1;
        for (int i = 0; i < BURST_WORDS; i++) send_word(OP_PUSH, 2'd1, pick_sample());
        for (int i = 0; i <= BURST_WORDS / CHANNELS_MAX; i++) send_word(OP_MIX, 2'd1, 16'h0000);
        send_word(OP_FLUSH, 2'd1, 16'h0000);
        steady = 1'b0;
    endtask

    // The result side stalls for a long while so the input backs up; then the
    // sender pauses until every frame is out.
    task automatic test_backpressure();
        wait_idle();
        set_mixer(pick_gain(), pick_gain(), pick_gain(), pick_gain(), 4'b0000, 4'd2);
        for (int t = 0; t < TRACKS; t++)
            for (int i = 0; i < 4; i++) send_word(OP_PUSH, t[TSEL_W-1:0], pick_sample());
        hold_req <= 1'b1;
        for (int k = 0; k < 4; k++) begin
            send_word(OP_MIX, 2'd0, 16'h0000);
            for (int t = 0; t < TRACKS; t++) send_word(OP_PUSH, t[TSEL_W-1:0], pick_sample());
        end
        while (hold_count < HOLD_CYCLES) @(posedge aclk);
        hold_req <= 1'b0;
        release_input();
        wait_drained();
        send_word(OP_MIX, 2'd0, 16'h0000);
        send_word(OP_MIX, 2'd0, 16'h0000);
    endtask

    // Mostly whole frames with random content, some stray words, over
    // several settings.
    task automatic test_random();
        int target;
        for (int phase = 0; phase < 5; phase++) begin
            wait_idle();
            case (phase)
                0: set_mixer(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, 4'b0000, 4'd8);
                1: set_mixer(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                             MUTE_W'($urandom_range(0, 15)), NCH_W'($urandom_range(0, 15)));
                2: set_mixer(pick_gain(), pick_gain(), pick_gain(), pick_gain(), 4'b0000, 4'd1);
                3: set_mixer(10'd1023, pick_gain(), 10'd1023, pick_gain(),
                             MUTE_W'($urandom_range(0, 15)), 4'd15);
                default: set_mixer(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                                   MUTE_W'($urandom_range(0, 7)),
                                   NCH_W'($urandom_range(1, 8)));
            endcase
            // One phase runs without idling on either side.
            steady = (phase == 2);
            target = words_sent + PHASE_WORDS;
            while (words_sent < target) begin
                if ($urandom_range(0, 4) != 0)
                    random_frame();
                else
                    send_word(op_t'($urandom_range(0, 3)), TSEL_W'($urandom_range(0, 3)),
                              SAMPLE_W'($urandom_range(0, 16'hFFFF)));
            end
        end
        steady = 1'b0;
    endtask

    // Result side: random stalls, or a counted hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            hold_count <= 0;
        end else if (hold_req && hold_count < HOLD_CYCLES) begin
            m_tready   <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            if (!hold_req) hold_count <= 0;
            m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Compare each accepted word with the oldest predicted one.
    always @(posedge aclk) begin : check_words
        mix_word_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_wr == due_rd) begin
                $display("%0t: unexpected word, expected none, got sample %0d channel %0d",
                         $time, $signed(m_tdata), m_tuser);
                errors++;
            end else begin
                due = due_mem[due_rd % DUE_DEPTH];
                due_rd++;
                words_checked++;
                if (m_tlast) frames_seen++;
                if (m_tdata !== due.mixed) begin
                    $display("%0t: mixed_sample mismatch, expected %0d, got %0d",
                             $time, $signed(due.mixed), $signed(m_tdata));
                    errors++;
                end
                if (m_tuser !== due.chan) begin
                    $display("%0t: channel_index mismatch, expected %0d, got %0d",
                             $time, due.chan, m_tuser);
                    errors++;
                end
                if (m_tlast !== due.last) begin
                    $display("%0t: frame_last mismatch, expected %0b, got %0b",
                             $time, due.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        for (int t = 0; t < TRACKS; t++) begin
            track_gain[t] = GAIN_RESET;
            rd_ptr[t] = 0;
            wr_ptr[t] = 0;
            fill[t]   = 0;
        end
        mute_bits      = '0;
        frame_channels = CHCNT_RESET;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_saturation();
        test_gain_limits();
        test_mute_and_flush();
        test_long_burst();
        test_backpressure();
        test_random();

        release_input();
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (due_wr != due_rd) begin
            $display("%0t: %0d predicted words never arrived", $time, due_wr - due_rd);
            errors++;
        end
        $display("Sent %0d words under %0d mixer settings;", words_sent, settings_used);
        $display("checked %0d mixed words in %0d frames.", words_checked, frames_seen);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #5000000;
        $display("%0t: run timed out", $time);
        $display("Test completed with failures");
        $finish;
    end

endmodule
